@@ hw/rtl/smt_pkg.sv @@
package smt_pkg;

    localparam int POS_BITS      = 16;
    localparam int MAX_TOKENS    = 4;
    localparam int TOK_IDX_BITS  = $clog2(MAX_TOKENS);
    localparam int TOK_CNT_BITS  = $clog2(MAX_TOKENS + 1);
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0] KIND_TEXT    = 4'd0;
    localparam logic [3:0] KIND_NEWLINE = 4'd1;
    localparam logic [3:0] KIND_OPEN    = 4'd2;
    localparam logic [3:0] KIND_CLOSE   = 4'd3;
    localparam logic [3:0] KIND_IDENT   = 4'd4;
    localparam logic [3:0] KIND_EQUAL   = 4'd5;
    localparam logic [3:0] KIND_BAR     = 4'd6;
    localparam logic [3:0] KIND_COMMENT = 4'd7;
    localparam logic [3:0] KIND_LABEL   = 4'd8;
    localparam logic [3:0] KIND_END     = 4'd9;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic [15:0] char_code;
        logic        last_char;
    } char_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_end;
        logic        last_token;
    } token_item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
    } token_t;

    // all tokens caused by one character
    typedef struct packed {
        token_t [MAX_TOKENS-1:0] tok;
        logic [TOK_IDX_BITS-1:0] last_idx;
    } bundle_t;

endpackage

@@ hw/rtl/script_markup_tokenizer.sv @@
// Script tokenizer: takes one character per cycle on the char channel and returns its tokens on
// the token channel, one token per transfer, in order, with last_token marking the final token
// of each character. A character is registered, classified in the following cycle and its
// tokens (up to four) are written as one entry into a four-entry queue, whose head entry
// supplies the token channel. Characters are taken back to back while the queue has room;
// the sustained rate is set by the token side, one token per cycle while token_ready is high,
// and a character that produces no tokens writes no queue entry.
// Positions count characters from zero and saturate at 65535.
module script_markup_tokenizer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  smt_pkg::char_item_t  char_data,
    output logic                 token_valid,
    input  logic                 token_ready,
    output smt_pkg::token_item_t token_data
);

    logic                                busy;
    logic                                bundle_valid;
    smt_pkg::bundle_t                    bundle;
    smt_pkg::bundle_t                    fifo_mem [smt_pkg::FIFO_DEPTH];
    smt_pkg::bundle_t                    head;
    logic [smt_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_reg;
    logic [smt_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_reg;
    logic [smt_pkg::FIFO_CNT_BITS-1:0]   count_reg;
    logic [smt_pkg::TOK_IDX_BITS-1:0]    sub_reg;
    logic                                load;
    logic                                tok_xfer;
    logic                                pop;

    smt_lexer u_lexer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .item         (char_data),
        .busy         (busy),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    // room for the character in flight plus the new one
    assign char_ready  = (count_reg + smt_pkg::FIFO_CNT_BITS'(busy))
                         < smt_pkg::FIFO_CNT_BITS'(smt_pkg::FIFO_DEPTH);
    assign load        = char_valid && char_ready;

    assign head        = fifo_mem[rd_ptr_reg];
    assign token_valid = (count_reg != '0);
    assign tok_xfer    = token_valid && token_ready;
    assign pop         = tok_xfer && (sub_reg == head.last_idx);

    assign token_data.token_kind  = head.tok[sub_reg].kind;
    assign token_data.token_start = head.tok[sub_reg].start_pos;
    assign token_data.token_end   = head.tok[sub_reg].end_pos;
    assign token_data.last_token  = (sub_reg == head.last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            if (bundle_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                sub_reg    <= '0;
            end
            else if (tok_xfer)
            begin
                sub_reg <= sub_reg + 1'b1;
            end
            if (bundle_valid && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!bundle_valid && pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle_valid)
        begin
            fifo_mem[wr_ptr_reg] <= bundle;
        end
    end

endmodule

@@ hw/rtl/smt_lexer.sv @@
module smt_lexer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  smt_pkg::char_item_t item,
    output logic                busy,
    output logic                bundle_valid,
    output smt_pkg::bundle_t    bundle
);

    localparam logic [3:0] M_LINE    = 4'd0;
    localparam logic [3:0] M_NORMAL  = 4'd1;
    localparam logic [3:0] M_NBRK    = 4'd2;
    localparam logic [3:0] M_TEXT    = 4'd3;
    localparam logic [3:0] M_TBRK    = 4'd4;
    localparam logic [3:0] M_CMD_AT  = 4'd5;
    localparam logic [3:0] M_CMD_BR  = 4'd6;
    localparam logic [3:0] M_ID_AT   = 4'd7;
    localparam logic [3:0] M_ID_BR   = 4'd8;
    localparam logic [3:0] M_STR_AT  = 4'd9;
    localparam logic [3:0] M_STR_BR  = 4'd10;
    localparam logic [3:0] M_COMMENT = 4'd11;
    localparam logic [3:0] M_LABEL   = 4'd12;
    localparam logic [3:0] M_HEAD    = 4'd13;

    localparam logic [15:0] CH_TAB     = 16'h0009;
    localparam logic [15:0] CH_LF      = 16'h000A;
    localparam logic [15:0] CH_SPACE   = 16'h0020;
    localparam logic [15:0] CH_CR      = 16'h000D;
    localparam logic [15:0] CH_IDSPACE = 16'h3000;
    localparam logic [15:0] CH_AT      = 16'h0040;
    localparam logic [15:0] CH_STAR    = 16'h002A;
    localparam logic [15:0] CH_SEMI    = 16'h003B;
    localparam logic [15:0] CH_LBRK    = 16'h005B;
    localparam logic [15:0] CH_RBRK    = 16'h005D;
    localparam logic [15:0] CH_EQUAL   = 16'h003D;
    localparam logic [15:0] CH_QUOTE   = 16'h0022;
    localparam logic [15:0] CH_TICK    = 16'h0060;
    localparam logic [15:0] CH_BAR     = 16'h007C;

    typedef struct packed {
        logic [3:0]    mode;
        smt_pkg::pos_t tbeg;
        logic [3:0]    pkind;
        smt_pkg::pos_t mark;
        logic          origin;
        logic [15:0]   prev;
        smt_pkg::pos_t cpos;
    } lex_state_t;

    typedef struct packed {
        lex_state_t       st;
        logic             cont;
        logic [1:0]       n;
        smt_pkg::token_t  t0;
        smt_pkg::token_t  t1;
    } pass_t;

    typedef struct packed {
        smt_pkg::token_t [smt_pkg::MAX_TOKENS-1:0] tok;
        logic [smt_pkg::TOK_CNT_BITS-1:0]          cnt;
    } acc_t;

    localparam lex_state_t RESET_STATE = '{
        mode:   M_LINE,
        tbeg:   '0,
        pkind:  smt_pkg::KIND_NEWLINE,
        mark:   '0,
        origin: 1'b1,
        prev:   '0,
        cpos:   '0
    };

    function automatic smt_pkg::pos_t sat_inc(smt_pkg::pos_t x);
        return (&x) ? x : x + 1'b1;
    endfunction

    function automatic logic is_space(logic [15:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_IDSPACE);
    endfunction

    function automatic smt_pkg::token_t mk(logic [3:0] k, smt_pkg::pos_t s, smt_pkg::pos_t e);
        smt_pkg::token_t t;
        t.kind      = k;
        t.start_pos = 16'(s);
        t.end_pos   = 16'(e);
        return t;
    endfunction

    // one visit of the mode switch; cont asks for another visit with the same character
    function automatic pass_t lex_pass(lex_state_t s, logic [15:0] c, smt_pkg::pos_t pos);
        pass_t r;
        logic  at;
        r      = '0;
        r.st   = s;
        at     = (s.mode == M_CMD_AT) || (s.mode == M_ID_AT) || (s.mode == M_STR_AT);
        case (s.mode)
            M_LINE:
            begin
                if (c == CH_TAB)
                begin
                end
                else if (c == CH_AT)
                begin
                    r.t0        = mk(smt_pkg::KIND_OPEN, s.tbeg, sat_inc(pos));
                    r.n         = 2'd1;
                    r.st.mode   = M_CMD_AT;
                    r.st.origin = 1'b0;
                end
                else if (c == CH_STAR)
                begin
                    r.t0        = mk(smt_pkg::KIND_LABEL, s.tbeg, sat_inc(pos));
                    r.n         = 2'd1;
                    r.st.mode   = M_LABEL;
                    r.st.tbeg   = sat_inc(pos);
                    r.st.pkind  = smt_pkg::KIND_IDENT;
                    r.st.origin = 1'b0;
                end
                else if (c == CH_SEMI)
                begin
                    r.st.mode   = M_COMMENT;
                    r.st.pkind  = smt_pkg::KIND_COMMENT;
                    r.st.origin = 1'b0;
                end
                else
                begin
                    if (!s.origin)
                    begin
                        r.t0 = mk(smt_pkg::KIND_NEWLINE, s.tbeg, pos);
                        r.n  = 2'd1;
                    end
                    r.st.origin = 1'b0;
                    r.st.mode   = M_NORMAL;
                    r.cont      = 1'b1;
                end
            end
            M_NORMAL:
            begin
                if (c == CH_LF)
                begin
                    r.st.mode  = M_LINE;
                    r.st.tbeg  = pos;
                    r.st.pkind = smt_pkg::KIND_NEWLINE;
                end
                else if (c == CH_LBRK)
                begin
                    r.st.mark = pos;
                    r.st.mode = M_NBRK;
                end
                else
                begin
                    r.st.tbeg  = pos;
                    r.st.pkind = smt_pkg::KIND_TEXT;
                    r.st.mode  = M_TEXT;
                end
            end
            M_NBRK:
            begin
                if (c == CH_LBRK)
                begin
                    r.st.tbeg  = pos;
                    r.st.pkind = smt_pkg::KIND_TEXT;
                    r.st.mode  = M_TEXT;
                end
                else
                begin
                    r.t0      = mk(smt_pkg::KIND_OPEN, s.mark, sat_inc(s.mark));
                    r.n       = 2'd1;
                    r.st.mode = M_CMD_BR;
                    r.cont    = 1'b1;
                end
            end
            M_TEXT:
            begin
                if (c == CH_LF)
                begin
                    r.t0       = mk(s.pkind, s.tbeg, pos);
                    r.n        = 2'd1;
                    r.st.mode  = M_LINE;
                    r.st.tbeg  = pos;
                    r.st.pkind = smt_pkg::KIND_NEWLINE;
                end
                else if (c == CH_LBRK)
                begin
                    r.st.mark = pos;
                    r.st.mode = M_TBRK;
                end
            end
            M_TBRK:
            begin
                if (c == CH_LBRK)
                begin
                    r.st.mode = M_TEXT;
                end
                else
                begin
                    r.t0      = mk(s.pkind, s.tbeg, s.mark);
                    r.t1      = mk(smt_pkg::KIND_OPEN, s.mark, sat_inc(s.mark));
                    r.n       = 2'd2;
                    r.st.mode = M_CMD_BR;
                    r.cont    = 1'b1;
                end
            end
            M_CMD_AT, M_CMD_BR:
            begin
                if (at && (c == CH_LF))
                begin
                    r.t0       = mk(smt_pkg::KIND_CLOSE, pos, sat_inc(pos));
                    r.n        = 2'd1;
                    r.st.mode  = M_LINE;
                    r.st.tbeg  = pos;
                    r.st.pkind = smt_pkg::KIND_NEWLINE;
                end
                else if (!at && (c == CH_RBRK))
                begin
                    r.t0      = mk(smt_pkg::KIND_CLOSE, pos, sat_inc(pos));
                    r.n       = 2'd1;
                    r.st.mode = M_NORMAL;
                end
                else if (is_space(c))
                begin
                end
                else if (c == CH_EQUAL)
                begin
                    r.t0 = mk(smt_pkg::KIND_EQUAL, pos, sat_inc(pos));
                    r.n  = 2'd1;
                end
                else
                begin
                    r.st.pkind = smt_pkg::KIND_IDENT;
                    if (c == CH_QUOTE)
                    begin
                        r.st.tbeg = sat_inc(pos);
                        r.st.mode = at ? M_STR_AT : M_STR_BR;
                    end
                    else
                    begin
                        r.st.tbeg = pos;
                        r.st.mode = at ? M_ID_AT : M_ID_BR;
                    end
                end
            end
            M_ID_AT, M_ID_BR:
            begin
                if (is_space(c) || (c == CH_EQUAL) || (c == CH_QUOTE) || (!at && (c == CH_RBRK)))
                begin
                    r.t0      = mk(s.pkind, s.tbeg, pos);
                    r.n       = 2'd1;
                    r.st.mode = at ? M_CMD_AT : M_CMD_BR;
                    r.cont    = 1'b1;
                end
            end
            M_STR_AT, M_STR_BR:
            begin
                if ((c == CH_QUOTE) && (s.prev != CH_TICK))
                begin
                    r.t0      = mk(s.pkind, s.tbeg, pos);
                    r.n       = 2'd1;
                    r.st.mode = at ? M_CMD_AT : M_CMD_BR;
                end
            end
            M_COMMENT, M_HEAD:
            begin
                if (c == CH_LF)
                begin
                    r.t0       = mk(s.pkind, s.tbeg, pos);
                    r.n        = 2'd1;
                    r.st.mode  = M_LINE;
                    r.st.tbeg  = pos;
                    r.st.pkind = smt_pkg::KIND_NEWLINE;
                end
            end
            M_LABEL:
            begin
                if (c == CH_LF)
                begin
                    r.t0       = mk(s.pkind, s.tbeg, pos);
                    r.n        = 2'd1;
                    r.st.mode  = M_LINE;
                    r.st.tbeg  = pos;
                    r.st.pkind = smt_pkg::KIND_NEWLINE;
                end
                else if (c == CH_BAR)
                begin
                    r.t0      = mk(s.pkind, s.tbeg, pos);
                    r.t1      = mk(smt_pkg::KIND_BAR, pos, sat_inc(pos));
                    r.n       = 2'd2;
                    r.st.tbeg = sat_inc(pos);
                    r.st.mode = M_HEAD;
                end
            end
            default:
            begin
                r.st.mode  = M_LINE;
                r.st.tbeg  = pos;
                r.st.pkind = smt_pkg::KIND_NEWLINE;
            end
        endcase
        return r;
    endfunction

    function automatic acc_t push(acc_t a, smt_pkg::token_t t);
        acc_t r;
        r = a;
        if (a.cnt < smt_pkg::TOK_CNT_BITS'(smt_pkg::MAX_TOKENS))
        begin
            r.tok[a.cnt[smt_pkg::TOK_IDX_BITS-1:0]] = t;
            r.cnt = a.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic acc_t push_pass(acc_t a, pass_t p);
        acc_t r;
        r = a;
        if (p.n != 2'd0)
        begin
            r = push(r, p.t0);
        end
        if (p.n == 2'd2)
        begin
            r = push(r, p.t1);
        end
        return r;
    endfunction

    smt_pkg::char_item_t item_reg;
    logic                busy_reg;
    lex_state_t          state_reg;
    lex_state_t          state_next;
    acc_t                acc;

    always_comb
    begin
        lex_state_t    s1;
        lex_state_t    s2;
        pass_t         p1;
        pass_t         p2;
        pass_t         p3;
        pass_t         p4;
        smt_pkg::pos_t end_pos;

        acc = '0;
        p1  = lex_pass(state_reg, item_reg.char_code, state_reg.cpos);
        s1  = p1.st;
        acc = push_pass(acc, p1);
        p2  = lex_pass(s1, item_reg.char_code, state_reg.cpos);
        if (p1.cont)
        begin
            s1  = p2.st;
            acc = push_pass(acc, p2);
        end
        s1.prev = item_reg.char_code;
        s1.cpos = sat_inc(state_reg.cpos);

        // implied newline, an ident for a string still open, then end token
        p3      = lex_pass(s1, CH_LF, s1.cpos);
        s2      = p3.st;
        p4      = lex_pass(s2, CH_LF, s1.cpos);
        end_pos = sat_inc(s1.cpos);
        if (item_reg.last_char)
        begin
            acc = push_pass(acc, p3);
            if (p3.cont)
            begin
                s2  = p4.st;
                acc = push_pass(acc, p4);
            end
            if ((s2.mode == M_STR_AT) || (s2.mode == M_STR_BR))
            begin
                acc = push(acc, mk(smt_pkg::KIND_IDENT, s2.tbeg, end_pos));
            end
            acc        = push(acc, mk(smt_pkg::KIND_END, end_pos, end_pos));
            state_next = RESET_STATE;
        end
        else
        begin
            state_next = s1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            state_reg <= RESET_STATE;
        end
        else
        begin
            busy_reg <= load;
            if (busy_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign busy            = busy_reg;
    assign bundle_valid    = busy_reg && (acc.cnt != '0);
    assign bundle.tok      = acc.tok;
    assign bundle.last_idx = smt_pkg::TOK_IDX_BITS'(acc.cnt - 1'b1);

endmodule

@@ tb/tb_script_markup_tokenizer.sv @@
`timescale 1ns / 100ps

module tb_script_markup_tokenizer;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_CHARS   = 160;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic [15:0] CH_NUL        = 16'h0000;
    localparam logic [15:0] CH_TAB        = 16'h0009;
    localparam logic [15:0] CH_NL         = 16'h000A;
    localparam logic [15:0] CH_SPACE      = 16'h0020;
    localparam logic [15:0] CH_QUOTE      = 16'h0022;
    localparam logic [15:0] CH_STAR       = 16'h002A;
    localparam logic [15:0] CH_SEMI       = 16'h003B;
    localparam logic [15:0] CH_EQUAL      = 16'h003D;
    localparam logic [15:0] CH_AT         = 16'h0040;
    localparam logic [15:0] CH_LBRK       = 16'h005B;
    localparam logic [15:0] CH_RBRK       = 16'h005D;
    localparam logic [15:0] CH_TICK       = 16'h0060;
    localparam logic [15:0] CH_BAR        = 16'h007C;
    localparam logic [15:0] CH_IDEO_SPACE = 16'h3000;
    localparam logic [15:0] CH_TOP        = 16'hFFFF;

    typedef enum logic [3:0] {
        LX_LINE,
        LX_NORMAL,
        LX_NBRK,
        LX_TEXT,
        LX_TBRK,
        LX_CMD_AT,
        LX_CMD_BR,
        LX_ID_AT,
        LX_ID_BR,
        LX_STR_AT,
        LX_STR_BR,
        LX_COMMENT,
        LX_LABEL,
        LX_HEAD
    } lex_mode_e;

    class token_tracker;
        smt_pkg::token_item_t expected_tokens[$];
        smt_pkg::token_t      step_tokens[$];
        int                   mismatches;
        int                   chars_seen;
        int                   tokens_seen;

        lex_mode_e   mode;
        logic [15:0] char_pos;
        logic [15:0] tok_begin;
        logic [15:0] prev_char;
        logic [15:0] mark_pos;
        logic [3:0]  pend_kind;
        bit          at_origin;

        function new();
            mismatches  = 0;
            chars_seen  = 0;
            tokens_seen = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode      = LX_LINE;
            char_pos  = '0;
            tok_begin = '0;
            prev_char = '0;
            mark_pos  = '0;
            pend_kind = smt_pkg::KIND_NEWLINE;
            at_origin = 1'b1;
        endfunction

        function logic [15:0] sat_inc(logic [15:0] x);
            return (x == CH_TOP) ? x : x + 16'd1;
        endfunction

        function bit is_blank(logic [15:0] c);
            return c == CH_SPACE || (c >= 16'h0009 && c <= 16'h000D) || c == CH_IDEO_SPACE;
        endfunction

        function void add_token(logic [3:0] kind, logic [15:0] s, logic [15:0] e);
            smt_pkg::token_t t;
            t.kind      = kind;
            t.start_pos = s;
            t.end_pos   = e;
            if (step_tokens.size() < smt_pkg::MAX_TOKENS)
                step_tokens.push_back(t);
        endfunction

        function void to_line(logic [15:0] pos);
            mode      = LX_LINE;
            tok_begin = pos;
            pend_kind = smt_pkg::KIND_NEWLINE;
        endfunction

        function void advance_lexer(logic [15:0] c, logic [15:0] pos);
            bit again;
            bit cmd_at;
            again = 1'b1;
            while (again)
            begin
                again  = 1'b0;
                cmd_at = (mode == LX_CMD_AT || mode == LX_ID_AT);
                case (mode)
                    LX_LINE:
                        if (c != CH_TAB)
                        begin
                            if (c == CH_AT)
                            begin
                                add_token(smt_pkg::KIND_OPEN, tok_begin, sat_inc(pos));
                                mode = LX_CMD_AT;
                            end
                            else if (c == CH_STAR)
                            begin
                                add_token(smt_pkg::KIND_LABEL, tok_begin, sat_inc(pos));
                                mode      = LX_LABEL;
                                tok_begin = sat_inc(pos);
                                pend_kind = smt_pkg::KIND_IDENT;
                            end
                            else if (c == CH_SEMI)
                            begin
                                mode      = LX_COMMENT;
                                pend_kind = smt_pkg::KIND_COMMENT;
                            end
                            else
                            begin
                                if (!at_origin)
                                    add_token(smt_pkg::KIND_NEWLINE, tok_begin, pos);
                                mode  = LX_NORMAL;
                                again = 1'b1;
                            end
                            at_origin = 1'b0;
                        end
                    LX_NORMAL:
                        if (c == CH_NL)
                            to_line(pos);
                        else if (c == CH_LBRK)
                        begin
                            mark_pos = pos;
                            mode     = LX_NBRK;
                        end
                        else
                        begin
                            tok_begin = pos;
                            pend_kind = smt_pkg::KIND_TEXT;
                            mode      = LX_TEXT;
                        end
                    LX_NBRK:
                        if (c == CH_LBRK)
                        begin
                            tok_begin = pos;
                            pend_kind = smt_pkg::KIND_TEXT;
                            mode      = LX_TEXT;
                        end
                        else
                        begin
                            add_token(smt_pkg::KIND_OPEN, mark_pos, sat_inc(mark_pos));
                            mode  = LX_CMD_BR;
                            again = 1'b1;
                        end
                    LX_TEXT:
                        if (c == CH_NL)
                        begin
                            add_token(pend_kind, tok_begin, pos);
                            to_line(pos);
                        end
                        else if (c == CH_LBRK)
                        begin
                            mark_pos = pos;
                            mode     = LX_TBRK;
                        end
                    LX_TBRK:
                        if (c == CH_LBRK)
                            mode = LX_TEXT;
                        else
                        begin
                            add_token(pend_kind, tok_begin, mark_pos);
                            add_token(smt_pkg::KIND_OPEN, mark_pos, sat_inc(mark_pos));
                            mode  = LX_CMD_BR;
                            again = 1'b1;
                        end
                    LX_CMD_AT, LX_CMD_BR:
                        if (cmd_at && c == CH_NL)
                        begin
                            add_token(smt_pkg::KIND_CLOSE, pos, sat_inc(pos));
                            to_line(pos);
                        end
                        else if (!cmd_at && c == CH_RBRK)
                        begin
                            add_token(smt_pkg::KIND_CLOSE, pos, sat_inc(pos));
                            mode = LX_NORMAL;
                        end
                        else if (!is_blank(c))
                        begin
                            if (c == CH_EQUAL)
                                add_token(smt_pkg::KIND_EQUAL, pos, sat_inc(pos));
                            else
                            begin
                                pend_kind = smt_pkg::KIND_IDENT;
                                if (c == CH_QUOTE)
                                begin
                                    tok_begin = sat_inc(pos);
                                    mode      = cmd_at ? LX_STR_AT : LX_STR_BR;
                                end
                                else
                                begin
                                    tok_begin = pos;
                                    mode      = cmd_at ? LX_ID_AT : LX_ID_BR;
                                end
                            end
                        end
                    LX_ID_AT, LX_ID_BR:
                        if (is_blank(c) || c == CH_EQUAL || c == CH_QUOTE
                            || (!cmd_at && c == CH_RBRK))
                        begin
                            add_token(pend_kind, tok_begin, pos);
                            mode  = cmd_at ? LX_CMD_AT : LX_CMD_BR;
                            again = 1'b1;
                        end
                    LX_STR_AT, LX_STR_BR:
                        if (c == CH_QUOTE && prev_char != CH_TICK)
                        begin
                            add_token(pend_kind, tok_begin, pos);
                            mode = (mode == LX_STR_AT) ? LX_CMD_AT : LX_CMD_BR;
                        end
                    LX_COMMENT, LX_HEAD:
                        if (c == CH_NL)
                        begin
                            add_token(pend_kind, tok_begin, pos);
                            to_line(pos);
                        end
                    LX_LABEL:
                        if (c == CH_NL)
                        begin
                            add_token(pend_kind, tok_begin, pos);
                            to_line(pos);
                        end
                        else if (c == CH_BAR)
                        begin
                            add_token(pend_kind, tok_begin, pos);
                            add_token(smt_pkg::KIND_BAR, pos, sat_inc(pos));
                            tok_begin = sat_inc(pos);
                            mode      = LX_HEAD;
                        end
                    default:
                        to_line(pos);
                endcase
            end
        endfunction

        function void note_char(smt_pkg::char_item_t item);
            smt_pkg::token_item_t t;
            chars_seen++;
            step_tokens.delete();
            advance_lexer(item.char_code, char_pos);
            prev_char = item.char_code;
            char_pos  = sat_inc(char_pos);
            if (item.last_char)
            begin
                // implied newline, an ident for a string still open, then the end marker
                advance_lexer(CH_NL, char_pos);
                prev_char = CH_NL;
                char_pos  = sat_inc(char_pos);
                if (mode == LX_STR_AT || mode == LX_STR_BR)
                    add_token(smt_pkg::KIND_IDENT, tok_begin, char_pos);
                add_token(smt_pkg::KIND_END, char_pos, char_pos);
                clear_state();
            end
            foreach (step_tokens[i])
            begin
                t.token_kind  = step_tokens[i].kind;
                t.token_start = step_tokens[i].start_pos;
                t.token_end   = step_tokens[i].end_pos;
                t.last_token  = (i == step_tokens.size() - 1);
                expected_tokens.push_back(t);
            end
        endfunction

        function void check_token(smt_pkg::token_item_t got);
            smt_pkg::token_item_t want;
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token transfer: kind %0d start %0d end %0d",
                       got.token_kind, got.token_start, got.token_end);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
            begin
                $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
                mismatches++;
            end
            if (got.token_start !== want.token_start)
            begin
                $error("token_start: expected %0d, got %0d", want.token_start, got.token_start);
                mismatches++;
            end
            if (got.token_end !== want.token_end)
            begin
                $error("token_end: expected %0d, got %0d", want.token_end, got.token_end);
                mismatches++;
            end
            if (got.last_token !== want.last_token)
            begin
                $error("last_token: expected %0b, got %0b", want.last_token, got.last_token);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 char_valid;
    logic                 char_ready;
    smt_pkg::char_item_t  char_data;
    logic                 token_valid;
    logic                 token_ready;
    smt_pkg::token_item_t token_data;

    token_tracker sb = new();

    logic [15:0] script_buf[$];
    bit          send_idle;
    bit          recv_idle;
    bit          hold_request;
    int          scripts_sent;
    int          random_chars;
    int          cycle_count;

    script_markup_tokenizer uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_length(bit enabled);
        int r;
        r = $urandom_range(0, 19);
        if (!enabled || r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // transfer monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && char_ready)
                sb.note_char(char_data);
            if (token_valid && token_ready)
                sb.check_token(token_data);
        end
    end

    // token sink with random stalls and one long hold-off on request
    initial
    begin : token_sink
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (stall == 0 && recv_idle && $urandom_range(0, 3) == 0)
                stall = idle_length(1'b1);
            if (stall > 0)
            begin
                token_ready <= 1'b0;
                stall--;
            end
            else
                token_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d tokens outstanding",
                 cycle_count, sb.expected_tokens.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void put(logic [15:0] c);
        script_buf.push_back(c);
    endfunction

    function automatic void put_word();
        int r;
        repeat ($urandom_range(1, 5))
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                put(16'($urandom_range(16'h61, 16'h7A)));
            else if (r < 9)
                put(16'($urandom_range(16'h30, 16'h39)));
            else
                put(16'($urandom_range(16'h0100, 16'hFFFF)));
        end
    endfunction

    function automatic void put_blank();
        case ($urandom_range(0, 3))
            0:       put(CH_TAB);
            1:       put(CH_IDEO_SPACE);
            default: put(CH_SPACE);
        endcase
    endfunction

    function automatic void put_quoted();
        put(CH_QUOTE);
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    put(CH_TICK);
                    put(CH_QUOTE);
                end
                1:       put(CH_TICK);
                2:       put_blank();
                3:       put(CH_EQUAL);
                default: put(16'($urandom_range(16'h61, 16'h7A)));
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            put(CH_QUOTE);
    endfunction

    function automatic void put_args();
        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(1, 2))
                put_blank();
            put_word();
            if ($urandom_range(0, 1))
            begin
                if ($urandom_range(0, 3) == 0)
                    put_blank();
                put(CH_EQUAL);
                if ($urandom_range(0, 3) == 0)
                    put_blank();
                if ($urandom_range(0, 1))
                    put_quoted();
                else
                    put_word();
            end
        end
    endfunction

    function automatic void put_noise(int n);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0: put(CH_TOP);
                1: put(CH_NUL);
                2: put(CH_IDEO_SPACE);
                3: put(16'($urandom_range(16'h0009, 16'h000D)));
                4: put(CH_RBRK);
                5: put(CH_BAR);
                default: put(16'($urandom_range(0, 65535)));
            endcase
        end
    endfunction

    function automatic void put_text();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 9))
                4:
                begin
                    put(CH_LBRK);
                    put(CH_LBRK);
                end
                5, 6:
                begin
                    put(CH_LBRK);
                    put_word();
                    put_args();
                    if ($urandom_range(0, 1))
                        put_blank();
                    put(CH_RBRK);
                end
                7: put(CH_TICK);
                8: put(CH_RBRK);
                9: put_noise(1);
                default:
                begin
                    put_word();
                    if ($urandom_range(0, 1))
                        put(CH_SPACE);
                end
            endcase
        end
    endfunction

    function automatic void build_script();
        script_buf.delete();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2))
                    put(CH_TAB);
            case ($urandom_range(0, 11))
                0, 1, 2:
                begin
                    put(CH_AT);
                    put_word();
                    put_args();
                end
                3, 4:
                begin
                    put(CH_STAR);
                    put_word();
                    if ($urandom_range(0, 1))
                    begin
                        put(CH_BAR);
                        put_text();
                    end
                end
                5:
                begin
                    put(CH_SEMI);
                    put_text();
                end
                6: put_noise($urandom_range(0, 1));
                7: put_noise($urandom_range(1, 6));
                default: put_text();
            endcase
            put(CH_NL);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            void'(script_buf.pop_back());
            case ($urandom_range(0, 3))
                0:
                begin
                    put(CH_LBRK);
                    put_word();
                end
                1:
                begin
                    put(CH_LBRK);
                    put_word();
                    put(CH_SPACE);
                    put(CH_QUOTE);
                    put_word();
                end
                default: put_word();
            endcase
        end
    endfunction

    task automatic send_char(input logic [15:0] code, input logic last);
        int gap;
        gap = idle_length(send_idle);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid          <= 1'b1;
        char_data.char_code <= code;
        char_data.last_char <= last;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
    endtask

    task automatic send_script();
        foreach (script_buf[i])
            send_char(script_buf[i], i == script_buf.size() - 1);
        scripts_sent++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_data    = '0;
        token_ready  = 1'b0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        hold_request = 1'b0;
        scripts_sent = 0;
        random_chars = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tabbed line command, wide space, escaped quote, label with bar, comment,
        // escaped bracket and a bracket command closing the script
        script_buf = '{CH_TAB, CH_AT, 16'("a"), CH_IDEO_SPACE, CH_EQUAL, CH_QUOTE, CH_TICK,
                       CH_QUOTE, CH_QUOTE, CH_NL, CH_STAR, 16'("L"), CH_BAR, CH_NL, CH_SEMI,
                       CH_NL, CH_LBRK, CH_LBRK, 16'("x"), CH_LBRK, 16'("y"), CH_RBRK};
        send_script();
        script_buf = '{CH_TOP};
        send_script();
        // open bracket command and open string at the end
        script_buf = '{CH_LBRK, CH_QUOTE, 16'("q")};
        send_script();

        while (random_chars < RANDOM_CHARS)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            build_script();
            random_chars += script_buf.size();
            send_script();
            if (random_chars >= RANDOM_CHARS / 2 && scripts_sent < 100)
            begin
                // long sink hold-off while a token-heavy command keeps coming
                send_idle    = 1'b0;
                hold_request = 1'b1;
                script_buf.delete();
                put(CH_LBRK);
                repeat (30) put(CH_EQUAL);
                put(CH_RBRK);
                send_script();
                scripts_sent += 100;
            end
        end
        char_valid <= 1'b0;

        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d characters in %0d scripts, %0d tokens compared",
                 sb.chars_seen, scripts_sent - 100, sb.tokens_seen);
        $display("covered commands, labels, comments, strings, escapes and stalls");
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/smt_pkg.sv
hw/rtl/smt_lexer.sv
hw/rtl/script_markup_tokenizer.sv
tb/tb_script_markup_tokenizer.sv
